// ===== rtl/monte_carlo_martingale_check_macros.svh =====
// Assertion helpers for the RTL.
`ifndef MONTE_CARLO_MARTINGALE_CHECK_MACROS_SVH
`define MONTE_CARLO_MARTINGALE_CHECK_MACROS_SVH

// Property checked at every rising edge outside reset.
`define MCMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define MCMC_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (nxt)) else $error(msg);

`endif

// ===== rtl/mcmc_pkg.sv =====
package mcmc_pkg;

  localparam int unsigned FracBits  = 24;
  localparam int unsigned MaxScen   = 4096;
  localparam int unsigned PosW      = $clog2(MaxScen);
  localparam int unsigned CntW      = PosW + 1;
  localparam int unsigned SumW      = 48;
  localparam int unsigned DivNW     = 2 * FracBits + 1;
  localparam int unsigned DivCntW   = $clog2(DivNW + 1);

  localparam logic [31:0]       One    = 32'(1) << FracBits;
  localparam logic [31:0]       Sat32  = '1;
  localparam logic [SumW-1:0]   SumMax = '1;
  localparam logic [CntW-1:0]   MaxCnt = CntW'(MaxScen);
  localparam logic [35:0]       TolMul = 36'd10;

  // Configuration register indexes.
  localparam logic [1:0] CfgCount = 2'd0;
  localparam logic [1:0] CfgMode  = 2'd1;
  localparam logic [1:0] CfgTol   = 2'd2;

  // One queued input beat.
  typedef struct packed {
    logic [31:0] factor;
    logic        restart;
  } item_t;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] numer;
    logic [31:0]      denom;
  } div_req_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivNW-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/mcmc_front.sv =====
module mcmc_front
  import mcmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_item_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output item_t       q_item_o
);

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_q];

  // Two-entry queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/mcmc_div.sv =====
module mcmc_div
  import mcmc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivNW-1:0]   n_q;
  logic [31:0]        d_q;
  logic [32:0]        r_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [32:0]        r_sh;
  logic               ge;

  // One quotient bit per cycle, restoring.
  assign r_sh = {r_q[31:0], n_q[DivNW-1]};
  assign ge   = (r_sh >= {1'b0, d_q});

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q <= req_i.numer;
      d_q <= req_i.denom;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= ge ? (r_sh - {1'b0, d_q}) : r_sh;
      n_q <= {n_q[DivNW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivNW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = n_q;

endmodule

// ===== rtl/mcmc_back.sv =====
`include "monte_carlo_martingale_check_macros.svh"

module mcmc_back
  import mcmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  item_t       q_item_i,
  input  logic [CntW-1:0] count_i,
  input  logic        mode_i,
  input  logic [31:0] tol_i,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_step_o,
  output logic        out_passed_o,
  output logic [31:0] out_dev_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SAT  = 3'd2;
  localparam logic [2:0] S_RCP  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_MEAN = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [31:0]       store_q [MaxScen];
  logic [31:0]       rd_q;
  logic [2:0]        state_q;
  logic [PosW-1:0]   pos_q;
  logic [SumW-1:0]   sum_q;
  logic [15:0]       step_q;
  logic              fail_q;
  logic [31:0]       factor_q, term_q, mean_q;
  logic [63:0]       prod64_q;
  logic              out_valid_q, out_passed_q;
  logic [15:0]       out_step_q;
  logic [31:0]       out_dev_q;

  logic [PosW-1:0]   rd_pos;
  logic [39:0]       shifted;
  logic [31:0]       prod_sat, prev, dev;
  logic [SumW:0]     sum_ext;
  logic [SumW-1:0]   sum_new;
  logic [35:0]       limit;
  logic              out_free, last, pop, wr_en;

  assign pop      = (state_q == S_IDLE) && q_valid_i;
  assign q_pop_o  = pop;
  assign rd_pos   = q_item_i.restart ? '0 : pos_q;
  assign prev     = (step_q == 16'd0) ? One : rd_q;
  assign shifted  = prod64_q[63:FracBits];
  assign prod_sat = (shifted[39:32] != 8'd0) ? Sat32 : shifted[31:0];
  assign wr_en    = (state_q == S_SAT);
  assign sum_ext  = {1'b0, sum_q} + {{(SumW-31){1'b0}}, term_q};
  assign sum_new  = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
  assign last     = ({1'b0, pos_q} + CntW'(1)) >= count_i;
  assign dev      = (mean_q >= One) ? (mean_q - One) : (One - mean_q);
  assign limit    = mode_i ? {4'd0, tol_i} : ({4'd0, tol_i} * TolMul);
  assign out_free = !out_valid_q || out_ready_i;

  // Divider requests: reciprocal of a nonzero product in mode 1, then the step mean.
  always_comb begin
    div_req_o = '0;
    if (state_q == S_SAT && mode_i && prod_sat != 32'd0) begin
      div_req_o.start = 1'b1;
      div_req_o.numer = DivNW'(1) << (2 * FracBits);
      div_req_o.denom = prod_sat;
    end else if (state_q == S_ACC && last) begin
      div_req_o.start = 1'b1;
      div_req_o.numer = {1'b0, sum_new};
      div_req_o.denom = {{(32-CntW){1'b0}}, count_i};
    end
  end

  // Product store: at most one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[pos_q] <= prod_sat;
    end
    rd_q <= store_q[rd_pos];
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop) factor_q <= q_item_i.factor;
    if (state_q == S_MUL) prod64_q <= 64'(prev) * 64'(factor_q);
    if (state_q == S_SAT) begin
      term_q <= mode_i ? Sat32 : prod_sat;
    end
    if (state_q == S_RCP && div_rsp_i.done) begin
      term_q <= (div_rsp_i.quo[DivNW-1:32] != '0) ? Sat32 : div_rsp_i.quo[31:0];
    end
    if (state_q == S_MEAN && div_rsp_i.done) mean_q <= div_rsp_i.quo[31:0];
  end

  // Sequencer and run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      sum_q       <= '0;
      step_q      <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            if (q_item_i.restart) begin
              pos_q  <= '0;
              sum_q  <= '0;
              step_q <= '0;
              fail_q <= 1'b0;
            end
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_SAT;
        S_SAT: state_q <= (mode_i && prod_sat != 32'd0) ? S_RCP : S_ACC;
        S_RCP: if (div_rsp_i.done) state_q <= S_ACC;
        S_ACC: begin
          sum_q <= sum_new;
          if (last) begin
            state_q <= S_MEAN;
          end else begin
            pos_q   <= pos_q + 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_MEAN: if (div_rsp_i.done) state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            if ({4'd0, dev} > limit) fail_q <= 1'b1;
            if (step_q != 16'hFFFF) step_q <= step_q + 1'b1;
            pos_q   <= '0;
            sum_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_step_q   <= step_q;
      out_dev_q    <= dev;
      out_passed_q <= !fail_q && !({4'd0, dev} > limit);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_step_o   = out_step_q;
  assign out_passed_o = out_passed_q;
  assign out_dev_o    = out_dev_q;

  `MCMC_ASSERT(a_div_owner, !div_rsp_i.busy || state_q == S_RCP || state_q == S_MEAN, "divider busy outside a wait state")
  `MCMC_ASSERT_NEXT(a_pop_mul, pop, state_q == S_MUL, "popped beat not multiplied next")
  `MCMC_ASSERT_NEXT(a_step_end, state_q == S_OUT && out_free, state_q == S_IDLE && pos_q == '0 && sum_q == '0 && out_valid_q, "step end did not clear run state")

endmodule

// ===== rtl/monte_carlo_martingale_check.sv =====
// Martingale check over Monte Carlo scenario streams.
// Input beats on s_axis: tdata carries one scenario's Q8.24 return factor,
// tuser set restarts the run (products taken as one, step zero) with this beat.
// Beats come in scenario order, scenario_count beats per time step.
// One result beat per completed step on m_axis: step number and |mean - 1|
// in tdata, pass flag (sticky fail until restart) in tuser.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i:
// index 0 scenario count, 1 check mode, 2 tolerance.
// Each beat passes through the sequencer steps store read, multiply,
// saturate, accumulate, and in mode 1 (unless the product is zero) the
// bit-serial reciprocal divider. A step end adds the mean, which uses the
// same divider, and the load of the result register.
// A two-beat queue in front lets the sender run ahead by two beats.
// Reset clears the run state and loads the register defaults; the product
// store needs no clearing. When the receiver stalls, the finished result waits
// in the output register and the block keeps taking beats until the next
// result is ready.
module monte_carlo_martingale_check
  import mcmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // return_factor
  input  logic        s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // step_number [15:0], deviation [47:16]
  output logic        m_axis_tuser,   // passed
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [CntW-1:0] count_q, count_eff;
  logic            mode_q;
  logic [31:0]     tol_q;
  item_t           in_item, q_item;
  logic            q_valid, q_pop;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  logic [15:0]     out_step;
  logic [31:0]     out_dev;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= MaxCnt;
      mode_q  <= 1'b0;
      tol_q   <= 32'd16777;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCount: count_q <= cfg_data_i[CntW-1:0];
        CfgMode:  mode_q  <= cfg_data_i[0];
        CfgTol:   tol_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the store depth as the depth.
  assign count_eff = (count_q == '0) ? CntW'(1) : (count_q > MaxCnt) ? MaxCnt : count_q;

  assign in_item.factor  = s_axis_tdata;
  assign in_item.restart = s_axis_tuser;

  mcmc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  mcmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  mcmc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_item_i     (q_item),
    .count_i      (count_eff),
    .mode_i       (mode_q),
    .tol_i        (tol_q),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_step_o   (out_step),
    .out_passed_o (m_axis_tuser),
    .out_dev_o    (out_dev)
  );

  assign m_axis_tdata = {out_dev, out_step};

endmodule

// ===== verif/tb_monte_carlo_martingale_check.sv =====
module tb_monte_carlo_martingale_check;
  import mcmc_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned SettleCycles = 400;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned WideItems = 300;

  // Expected content of one step report.
  typedef struct {
    logic [15:0] step;
    logic        passed;
    logic [31:0] dev;
  } step_report_t;

  // Tracks the martingale state and holds the step reports still to come.
  class martingale_scoreboard;
    logic [31:0]  prod_store [MaxScen];
    logic [47:0]  sum;
    int unsigned  pos;
    logic [15:0]  step;
    bit           failed;
    logic [12:0]  count_reg;
    bit           mode_reg;
    logic [31:0]  tol_reg;
    step_report_t reports_q[$];
    int unsigned  errors;
    int unsigned  beats_in;
    int unsigned  reports_seen;

    function new();
      sum = '0;
      pos = 0;
      step = '0;
      failed = 0;
      count_reg = 13'd4096;
      mode_reg = 0;
      tol_reg = 32'd16777;
      errors = 0;
      beats_in = 0;
      reports_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CfgCount: count_reg = data[12:0];
        CfgMode:  mode_reg = data[0];
        CfgTol:   tol_reg = data;
        default: ;
      endcase
    endfunction

    // Folds one factor into the running products; predicts a report at step end.
    function void note_factor(logic [31:0] factor, bit restart);
      logic [63:0]  wide;
      logic [31:0]  prev;
      logic [31:0]  prod;
      logic [31:0]  term;
      logic [48:0]  acc;
      logic [47:0]  mean;
      logic [47:0]  diff;
      logic [35:0]  limit;
      int unsigned  cnt;
      step_report_t rep;
      beats_in++;
      cnt = (count_reg == 0) ? 1 : ((count_reg > MaxScen) ? MaxScen : count_reg);
      if (restart) begin
        sum = '0;
        pos = 0;
        step = '0;
        failed = 0;
      end
      prev = (step == 0) ? One : prod_store[pos];
      wide = (64'(prev) * 64'(factor)) >> FracBits;
      prod = (wide > 64'(Sat32)) ? Sat32 : wide[31:0];
      prod_store[pos] = prod;
      if (!mode_reg) begin
        term = prod;
      end else if (prod == 0) begin
        term = Sat32;
      end else begin
        wide = (64'd1 << (2 * FracBits)) / 64'(prod);
        term = (wide > 64'(Sat32)) ? Sat32 : wide[31:0];
      end
      acc = 49'(sum) + 49'(term);
      sum = acc[48] ? SumMax : acc[47:0];
      if (pos + 1 < cnt) begin
        pos++;
        return;
      end
      mean = sum / 48'(cnt);
      diff = (mean >= 48'(One)) ? mean - 48'(One) : 48'(One) - mean;
      limit = mode_reg ? 36'(tol_reg) : 36'(tol_reg) * TolMul;
      if (36'(diff[31:0]) > limit) failed = 1;
      rep.step = step;
      rep.passed = !failed;
      rep.dev = diff[31:0];
      reports_q.push_back(rep);
      if (step != 16'hFFFF) step++;
      pos = 0;
      sum = '0;
    endfunction

    // Compares one result beat with the oldest predicted report.
    function void check_report(logic [47:0] data, logic passed);
      step_report_t want;
      reports_seen++;
      if (reports_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: data=%h passed=%b", data, passed);
        return;
      end
      want = reports_q.pop_front();
      if (data[15:0] !== want.step || data[47:16] !== want.dev || passed !== want.passed) begin
        errors++;
        if (errors <= 10)
          $display("report mismatch: expected step=%0d dev=%h passed=%b, got step=%0d dev=%h passed=%b",
                   want.step, want.dev, want.passed, data[15:0], data[47:16], passed);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // return_factor
  logic        s_axis_tuser;   // restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // step_number [15:0], deviation [47:16]
  logic        m_axis_tuser;   // passed
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  martingale_scoreboard sb;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned phase_count;

  monte_carlo_martingale_check dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter with a hard stop.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check accepted beats and stall on a pattern that rotates through four settings.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata, m_axis_tuser);
    case ((cycle_count / 400) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= ((cycle_count % 8) == 0);
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Sends one beat; bursts of random length are mostly separated by random gaps.
  task automatic send_factor(logic [31:0] factor, bit restart);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= factor;
    s_axis_tuser <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_factor(factor, restart);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.reports_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(logic [12:0] count, bit mode, logic [31:0] tol);
    wait_idle();
    write_reg(CfgCount, 32'(count));
    write_reg(CfgMode, 32'(mode));
    write_reg(CfgTol, tol);
    phase_count++;
  endtask

  // Mostly factors close to one, with some extremes and fully random words.
  function automatic logic [31:0] pick_factor();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return One - 32'h8_0000 + 32'($urandom_range(0, 32'h10_0000));
    if (sel < 85) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return Sat32;
      2: return 32'h1;
      default: return One;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned pause_at;
    logic [12:0] count;
    logic [31:0] tol;
    sb = new();
    cycle_count = 0;
    burst_left = 0;
    phase_count = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgCount;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A count of zero acts as one; zero tolerance makes the fail flag stick.
    configure(13'd0, 1'b0, 32'h0);
    send_factor(One, 1'b1);
    send_factor(Sat32, 1'b0);
    send_factor(Sat32, 1'b0);
    send_factor(32'h0, 1'b0);
    send_factor(One, 1'b0);
    send_factor(32'h8000_0000, 1'b1);
    send_factor(32'h1, 1'b1);
    send_factor(One, 1'b1);

    // Reciprocal mode with a zero product and the widest tolerance.
    configure(13'd3, 1'b1, Sat32);
    send_factor(32'h0, 1'b1);
    send_factor(Sat32, 1'b0);
    send_factor(One, 1'b0);
    send_factor(32'h1, 1'b0);
    send_factor(Sat32, 1'b0);
    send_factor(32'h2, 1'b0);
    send_factor(One, 1'b0);
    send_factor(32'h5555_5555, 1'b1);
    send_factor(32'hAAAA_AAAA, 1'b0);

    // A count above the store size acts as the full store, so no step ends here.
    configure(13'h1FFF, 1'b0, 32'd16777);
    for (int unsigned i = 0; i < WideItems; i++)
      send_factor(One - 32'h1000 + 32'($urandom_range(0, 32'h2000)), i == 0);

    // Random phases; every phase starts with a restart since the count may have grown.
    sent = 0;
    pause_at = $urandom_range(100, 600);
    while (sent < RandomItems) begin
      case ($urandom_range(0, 5))
        0: count = 13'd1;
        1: count = 13'd2;
        2: count = 13'($urandom_range(25, 64));
        default: count = 13'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 3))
        0: tol = 32'h0;
        1: tol = Sat32;
        2: tol = $urandom;
        default: tol = 32'($urandom_range(0, 32'h10_0000));
      endcase
      configure(count, $urandom_range(0, 1), tol);
      n = count * $urandom_range(2, 10);
      for (int unsigned i = 0; i < n; i++) begin
        if (sent == pause_at) begin
          s_axis_tvalid <= 1'b0;
          while (sb.reports_q.size() != 0) @(posedge clk_i);
          @(posedge clk_i);
        end
        send_factor(pick_factor(), i == 0 || $urandom_range(0, 99) < 2);
        sent++;
      end
    end

    wait_idle();
    $display("Sent %0d factor beats over %0d register settings; checked %0d step reports.",
             sb.beats_in, phase_count, sb.reports_seen);
    if (sb.errors == 0 && sb.reports_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mcmc_pkg.sv
rtl/mcmc_front.sv
rtl/mcmc_div.sv
rtl/mcmc_back.sv
rtl/monte_carlo_martingale_check.sv
verif/tb_monte_carlo_martingale_check.sv
